// File: sv/lira_pkg.sv
// ----------------------------------------------------------------------------
// lira_pkg
// Shared types, constants and helpers of the line-interleaved RGB to pixel
// assembler.
// ----------------------------------------------------------------------------
package lira_pkg;

  // Default line store depth (pixels)
  localparam int MAX_WIDTH_DEF = 8192;

  // Configuration register widths and reset values
  localparam int LW_W = 14;
  localparam int IH_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 14'd8192;
  localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 16'hFFFF;

  // Configuration register indexes
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Stream field widths
  localparam int SAMPLE_W = 8;
  localparam int ROW_NUM_W = 18;
  localparam int COL_W = 13;
  localparam int OUT_ROW_W = 16;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 56;

  // Input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // Colour channels
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // White fill value
  localparam logic [SAMPLE_W-1:0] WHITE = 8'd255;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command kinds handed from front to back
  localparam logic [1:0] KIND_WR_RED   = 2'd0;
  localparam logic [1:0] KIND_WR_GREEN = 2'd1;
  localparam logic [1:0] KIND_PIXEL    = 2'd2;
  localparam logic [1:0] KIND_FILL     = 2'd3;

  // Command fields (the column travels beside it, its width follows the depth)
  typedef struct packed {
    logic [1:0]           kind;
    logic                 line_end;
    logic [OUT_ROW_W-1:0] out_row;
    logic [SAMPLE_W-1:0]  sample;
  } cmd_t;

  // Row number modulo 3: base-4 digits each weigh 1 mod 3
  function automatic logic [1:0] mod3(input logic [ROW_NUM_W-1:0] x);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    logic [1:0] r;
    s1 = '0;
    for (int i = 0; i < ROW_NUM_W / 2; i++) begin
      s1 = s1 + {3'b000, x[2*i +: 2]};
    end
    s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'b00, s1[4]};
    s3 = {1'b0, s2[1:0]} + {2'b00, s2[2]};
    if (s3 >= 3'd3) begin
      r = 2'(s3 - 3'd3);
    end else begin
      r = s3[1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/line_interleaved_rgb_to_pixel_assembler_core.sv
// ----------------------------------------------------------------------------
// line_interleaved_rgb_to_pixel_assembler_core
// Turns line-sequential scanner sample bytes into interleaved RGB pixels.
// ----------------------------------------------------------------------------
// One beat is accepted per clock and one pixel leaves per clock when the
// result side keeps tready high. A blue byte or fill beat passes through the
// queue, the read stage, where the line store is read, and the output
// register before its pixel is offered. The rate is set by the line store,
// which takes one read or one write per cycle. After reset the line store is
// swept to zero, one entry per cycle, over all MAX_WIDTH entries (8192 at the
// default); in_tready stays low for that time while configuration writes are
// taken as usual. Red and green bytes and beats after the last image line give
// no pixel.
module line_interleaved_rgb_to_pixel_assembler_core #(
  parameter int MAX_WIDTH = lira_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [lira_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sample[7:0], row_number[25:8], mirror[26], zero[31:27]
  input  logic [lira_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // column[12:0], out_row[28:13], red[36:29], green[44:37], blue[52:45],
  // zero[55:53]
  output logic [lira_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int QW  = $bits(lira_pkg::cmd_t) + AW;
  localparam int CMW = $bits(lira_pkg::cmd_t);

  logic            clearing;
  logic            q_full, q_vld, q_push, q_pop;
  lira_pkg::cmd_t  push_cmd, head_cmd;
  logic [AW-1:0]   push_col, head_col;
  logic [QW-1:0]   head_data;

  lira_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .push_cmd  (push_cmd),
    .push_col  (push_col)
  );

  lira_queue #(
    .WIDTH (QW),
    .DEPTH (lira_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_col, push_cmd}),
    .pop       (q_pop),
    .head_data (head_data),
    .q_vld     (q_vld),
    .q_full    (q_full)
  );

  assign head_cmd = lira_pkg::cmd_t'(head_data[CMW-1:0]);
  assign head_col = head_data[CMW +: AW];

  lira_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .head_cmd   (head_cmd),
    .head_col   (head_col),
    .pop        (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // No beat is taken while the line store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("beat accepted during line store clear");

  // Nothing queued or shown while the store is being cleared
  a_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!q_vld && !out_tvalid))
    else $error("command or pixel present during line store clear");

  // The queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue overflow");

endmodule

// File: sv/lira_ram.sv
// ----------------------------------------------------------------------------
// lira_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/lira_front.sv
// ----------------------------------------------------------------------------
// lira_front
// Accepts beats, holds configuration and position state, classifies each
// beat into a store write, a pixel or a fill command for the back end.
// ----------------------------------------------------------------------------
module lira_front #(
  parameter int MAX_WIDTH = lira_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [lira_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lira_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  logic                                clearing,
  input  logic                                q_full,
  output logic                                q_push,
  output lira_pkg::cmd_t                      push_cmd,
  output logic [AW-1:0]                       push_col
);

  logic [lira_pkg::LW_W-1:0]      lw_r;
  logic [lira_pkg::IH_W-1:0]      ih_r;
  logic [AW-1:0]                  row_pos_r, row_pos_nxt;
  logic [AW-1:0]                  fill_pos_r, fill_pos_nxt;
  logic [lira_pkg::OUT_ROW_W-1:0] lines_done_r, lines_done_nxt;

  logic [AW-1:0]                  eff_m1;
  logic [AW-1:0]                  rpos, fpos;
  logic                           r_end, f_end;
  logic [1:0]                     channel;
  logic                           accept;
  logic                           image_open;
  logic                           opcode;
  logic [lira_pkg::SAMPLE_W-1:0]  sample;
  logic [lira_pkg::ROW_NUM_W-1:0] row_number;
  logic                           mirror;

  // Beat fields: sample, row_number, mirror from bit 0 up; opcode in tuser
  assign opcode     = in_tuser;
  assign sample     = in_tdata[7:0];
  assign row_number = in_tdata[25:8];
  assign mirror     = in_tdata[26];

  assign in_tready  = !clearing && !q_full;
  assign accept     = in_tvalid && in_tready;
  assign image_open = lines_done_r < ih_r;

  // Last position of a line; width 0 acts as 1, above the depth acts as depth
  always_comb begin
    if (lw_r == '0) begin
      eff_m1 = '0;
    end else if (32'(lw_r) > 32'(MAX_WIDTH)) begin
      eff_m1 = AW'(MAX_WIDTH - 1);
    end else begin
      eff_m1 = AW'(lw_r - 14'd1);
    end
  end

  // Positions restart when the width was lowered below them
  assign rpos    = (row_pos_r > eff_m1) ? '0 : row_pos_r;
  assign fpos    = (fill_pos_r > eff_m1) ? '0 : fill_pos_r;
  assign r_end   = rpos == eff_m1;
  assign f_end   = fpos == eff_m1;
  assign channel = lira_pkg::mod3(row_number);

  // Classification and position update
  always_comb begin
    q_push           = 1'b0;
    push_cmd.kind    = lira_pkg::KIND_FILL;
    push_cmd.line_end = 1'b0;
    push_cmd.out_row = lines_done_r;
    push_cmd.sample  = sample;
    push_col         = rpos;
    row_pos_nxt      = row_pos_r;
    fill_pos_nxt     = fill_pos_r;
    lines_done_nxt   = lines_done_r;
    if (accept) begin
      if (opcode == lira_pkg::OP_FILL) begin
        push_col          = fpos;
        push_cmd.line_end = f_end;
        if (image_open) begin
          q_push       = 1'b1;
          fill_pos_nxt = f_end ? '0 : fpos + 1'b1;
          if (f_end) begin
            lines_done_nxt = lines_done_r + 1'b1;
          end
        end
      end else begin
        push_col          = mirror ? eff_m1 - rpos : rpos;
        push_cmd.line_end = r_end;
        row_pos_nxt       = r_end ? '0 : rpos + 1'b1;
        case (channel)
          lira_pkg::CH_RED: begin
            q_push        = 1'b1;
            push_cmd.kind = lira_pkg::KIND_WR_RED;
          end
          lira_pkg::CH_GREEN: begin
            q_push        = 1'b1;
            push_cmd.kind = lira_pkg::KIND_WR_GREEN;
          end
          default: begin
            push_cmd.kind = lira_pkg::KIND_PIXEL;
            if (image_open) begin
              q_push = 1'b1;
              if (r_end) begin
                lines_done_nxt = lines_done_r + 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= lira_pkg::LINE_WIDTH_RST;
      ih_r <= lira_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lira_pkg::REG_LINE_WIDTH:   lw_r <= cfg_data[lira_pkg::LW_W-1:0];
        lira_pkg::REG_IMAGE_HEIGHT: ih_r <= cfg_data[lira_pkg::IH_W-1:0];
        default: ;
      endcase
    end
  end

  // Position and line counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r    <= '0;
      fill_pos_r   <= '0;
      lines_done_r <= '0;
    end else begin
      row_pos_r    <= row_pos_nxt;
      fill_pos_r   <= fill_pos_nxt;
      lines_done_r <= lines_done_nxt;
    end
  end

endmodule

// File: sv/lira_queue.sv
// ----------------------------------------------------------------------------
// lira_queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module lira_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lira_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             q_vld,
  output logic             q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign q_vld     = count_r != '0;
  assign q_full    = count_r == CW'(DEPTH);
  assign head_data = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/lira_back.sv
// ----------------------------------------------------------------------------
// lira_back
// Carries out queued commands: line store writes, pixel reads and fills,
// with an output register towards the result stream. Clears the line store
// after reset.
// ----------------------------------------------------------------------------
module lira_back #(
  parameter int MAX_WIDTH = lira_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_vld,
  input  lira_pkg::cmd_t                   head_cmd,
  input  logic [AW-1:0]                    head_col,
  output logic                             pop,
  output logic                             clearing,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lira_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  logic                           clearing_r;
  logic [AW-1:0]                  clr_addr_r;

  logic                           a_vld_r;
  lira_pkg::cmd_t                 a_cmd_r;
  logic [AW-1:0]                  a_col_r;
  logic                           a_emit;
  logic                           a_go;
  logic                           b_free;

  logic                           out_vld_r;
  logic [lira_pkg::COL_W-1:0]     out_col_r;
  logic [lira_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [lira_pkg::SAMPLE_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic                           out_last_r;

  logic                           red_we, green_we, rd_en;
  logic [AW-1:0]                  waddr;
  logic [lira_pkg::SAMPLE_W-1:0]  wdata;
  logic [lira_pkg::SAMPLE_W-1:0]  red_q, green_q;

  // Handshake between stages
  assign b_free = !out_vld_r || out_tready;
  assign a_emit = (a_cmd_r.kind == lira_pkg::KIND_PIXEL) ||
                  (a_cmd_r.kind == lira_pkg::KIND_FILL);
  assign a_go   = a_vld_r && (!a_emit || b_free);
  assign pop    = q_vld && !clearing_r && (!a_vld_r || a_go);

  // Line store port control; the clearing pass owns the write port
  assign waddr    = clearing_r ? clr_addr_r : head_col;
  assign wdata    = clearing_r ? '0 : head_cmd.sample;
  assign red_we   = clearing_r || (pop && head_cmd.kind == lira_pkg::KIND_WR_RED);
  assign green_we = clearing_r || (pop && head_cmd.kind == lira_pkg::KIND_WR_GREEN);
  assign rd_en    = pop && head_cmd.kind == lira_pkg::KIND_PIXEL;

  lira_ram #(
    .WIDTH (lira_pkg::SAMPLE_W),
    .DEPTH (MAX_WIDTH)
  ) u_red_store (
    .clk   (clk),
    .we    (red_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (head_col),
    .rdata (red_q)
  );

  lira_ram #(
    .WIDTH (lira_pkg::SAMPLE_W),
    .DEPTH (MAX_WIDTH)
  ) u_green_store (
    .clk   (clk),
    .we    (green_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (head_col),
    .rdata (green_q)
  );

  // Clearing pass over the line store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign clearing = clearing_r;

  // Read stage: command waits here while store data comes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (pop) begin
      a_vld_r <= 1'b1;
    end else if (a_go) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_cmd_r <= head_cmd;
      a_col_r <= head_col;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (a_go && a_emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_emit) begin
      out_col_r  <= lira_pkg::COL_W'(a_col_r);
      out_row_r  <= a_cmd_r.out_row;
      out_last_r <= a_cmd_r.line_end;
      if (a_cmd_r.kind == lira_pkg::KIND_FILL) begin
        out_red_r   <= lira_pkg::WHITE;
        out_green_r <= lira_pkg::WHITE;
        out_blue_r  <= lira_pkg::WHITE;
      end else begin
        out_red_r   <= red_q;
        out_green_r <= green_q;
        out_blue_r  <= a_cmd_r.sample;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_blue_r, out_green_r, out_red_r, out_row_r, out_col_r};

endmodule

// File: dv/line_interleaved_rgb_to_pixel_assembler_core_tb.sv
// ----------------------------------------------------------------------------
// line_interleaved_rgb_to_pixel_assembler_core_tb
// Self-checking bench for the RGB line-to-pixel assembler. A behavioural copy
// of the line store, position counters and line count predicts every pixel
// as its beat is accepted. A monitor compares each pixel leaving the core
// with the oldest prediction, field by field. The stimulus runs directed
// checks of the reset values, the width limits, the fill step and the
// finished image, and then randomised scan lines, fill runs and noise under
// changing settings. Both stream sides idle at random throughout.
// ----------------------------------------------------------------------------
module line_interleaved_rgb_to_pixel_assembler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BEATS = 1250;
  localparam int HOLD_OFF    = 12;     // pipeline depth plus margin
  localparam int IDLE_LIMIT  = 50000;  // covers the line store sweep after reset

  // Field layout of the stream words, lowest field last
  typedef struct packed {
    logic [4:0]                     pad;
    logic                           mirror;
    logic [lira_pkg::ROW_NUM_W-1:0] row;
    logic [lira_pkg::SAMPLE_W-1:0]  sample;
  } in_word_t;

  typedef struct packed {
    logic [2:0]                     pad;
    logic [lira_pkg::SAMPLE_W-1:0]  blue;
    logic [lira_pkg::SAMPLE_W-1:0]  green;
    logic [lira_pkg::SAMPLE_W-1:0]  red;
    logic [lira_pkg::OUT_ROW_W-1:0] out_row;
    logic [lira_pkg::COL_W-1:0]     column;
  } out_word_t;

  typedef struct {
    logic [lira_pkg::COL_W-1:0]     column;
    logic [lira_pkg::OUT_ROW_W-1:0] out_row;
    logic [lira_pkg::SAMPLE_W-1:0]  red;
    logic [lira_pkg::SAMPLE_W-1:0]  green;
    logic [lira_pkg::SAMPLE_W-1:0]  blue;
    logic                           line_end;
  } pixel_t;

  typedef enum int {RDY_FREE, RDY_COIN, RDY_COMB, RDY_SPARSE} rdy_mode_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic                            cfg_index  = lira_pkg::REG_LINE_WIDTH;
  logic [lira_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [lira_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = lira_pkg::OP_SAMPLE;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lira_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // Predicted core state
  logic [15:0]                     store_m [lira_pkg::MAX_WIDTH_DEF];
  logic [lira_pkg::COL_W-1:0]      row_pos_m;
  logic [lira_pkg::COL_W-1:0]      fill_pos_m;
  logic [lira_pkg::OUT_ROW_W-1:0]  lines_m;
  logic [lira_pkg::LW_W-1:0]       width_m;
  logic [lira_pkg::IH_W-1:0]       height_m;

  pixel_t    expected_pixels[$];
  int        errors      = 0;
  int        beats_sent  = 0;
  int        burst_left  = 0;
  int        idle_cycles = 0;
  rdy_mode_t rdy_mode    = RDY_FREE;
  int        rdy_left    = 0;

  line_interleaved_rgb_to_pixel_assembler_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  task automatic reset_prediction();
    foreach (store_m[i]) store_m[i] = '0;
    row_pos_m  = '0;
    fill_pos_m = '0;
    lines_m    = '0;
    width_m    = lira_pkg::LINE_WIDTH_RST;
    height_m   = lira_pkg::IMAGE_HEIGHT_RST;
  endtask

  // Zero acts as one, anything above the store depth as the full depth
  function automatic int active_width();
    if (width_m == 0) return 1;
    if (int'(width_m) > lira_pkg::MAX_WIDTH_DEF) return lira_pkg::MAX_WIDTH_DEF;
    return int'(width_m);
  endfunction

  task automatic predict_pixel(input logic op,
                               input logic [lira_pkg::SAMPLE_W-1:0] s,
                               input logic [lira_pkg::ROW_NUM_W-1:0] r,
                               input logic m);
    int         w;
    int         pos;
    int         col;
    logic [1:0] chan;
    logic       ends_line;
    pixel_t     px;
    w = active_width();
    if (op == lira_pkg::OP_FILL) begin
      pos = (int'(fill_pos_m) >= w) ? 0 : int'(fill_pos_m);
      // finished image: nothing out, fill position held
      if (lines_m < height_m) begin
        ends_line   = (pos == w - 1);
        px.column   = lira_pkg::COL_W'(pos);
        px.out_row  = lines_m;
        px.red      = lira_pkg::WHITE;
        px.green    = lira_pkg::WHITE;
        px.blue     = lira_pkg::WHITE;
        px.line_end = ends_line;
        expected_pixels.push_back(px);
        if (ends_line) lines_m++;
        fill_pos_m = ends_line ? '0 : lira_pkg::COL_W'(pos + 1);
      end
    end else begin
      pos       = (int'(row_pos_m) >= w) ? 0 : int'(row_pos_m);
      chan      = 2'(int'(r) % 3);
      col       = m ? (w - 1 - pos) : pos;
      ends_line = (pos == w - 1);
      if (chan == lira_pkg::CH_RED) begin
        store_m[col][7:0] = s;
      end else if (chan == lira_pkg::CH_GREEN) begin
        store_m[col][15:8] = s;
      end else if (lines_m < height_m) begin
        px.column   = lira_pkg::COL_W'(col);
        px.out_row  = lines_m;
        px.red      = store_m[col][7:0];
        px.green    = store_m[col][15:8];
        px.blue     = s;
        px.line_end = ends_line;
        expected_pixels.push_back(px);
        if (ends_line) lines_m++;
      end
      row_pos_m = ends_line ? '0 : lira_pkg::COL_W'(pos + 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic op,
                           input logic [lira_pkg::SAMPLE_W-1:0] s,
                           input logic [lira_pkg::ROW_NUM_W-1:0] r,
                           input logic m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= in_word_t'{pad: '0, mirror: m, row: r, sample: s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(op, s, r, m);
    beats_sent++;
    burst_left--;
  endtask

  // Stop sending and wait for every predicted pixel, then for the pipeline
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Registers only change with the core idle
  task automatic apply_setting(input logic [lira_pkg::CFG_DATA_W-1:0] w,
                               input logic [lira_pkg::CFG_DATA_W-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= lira_pkg::REG_LINE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= lira_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_m  = w[lira_pkg::LW_W-1:0];
    height_m = h[lira_pkg::IH_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
      rdy_left <= $urandom_range(16, 160);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RDY_FREE: out_tready <= 1'b1;
      RDY_COIN: out_tready <= ($urandom_range(0, 1) == 1);
      RDY_COMB: out_tready <= (rdy_left % 4 != 0);
      default:  out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Pixel check
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t    want;
    out_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_word_t'(out_tdata);
      if (expected_pixels.size() == 0) begin
        $error("pixel beat with none predicted: column %0d row %0d",
               got.column, got.out_row);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("column",   32'(want.column),   32'(got.column));
        check_field("out_row",  32'(want.out_row),  32'(got.out_row));
        check_field("red",      32'(want.red),      32'(got.red));
        check_field("green",    32'(want.green),    32'(got.green));
        check_field("blue",     32'(want.blue),     32'(got.blue));
        check_field("line_end", 32'(want.line_end), 32'(out_tlast));
      end
    end
  end

  // Watchdog on beats moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: full width, full height, zero store
  task automatic test_reset_defaults();
    send_beat(lira_pkg::OP_SAMPLE, 8'hFF, 18'd262143, 1'b0);  // red, column 0
    send_beat(lira_pkg::OP_SAMPLE, 8'h00, 18'd1, 1'b1);       // green, mirrored
    send_beat(lira_pkg::OP_SAMPLE, 8'hAA, 18'd262142, 1'b1);  // blue on untouched entry
    send_beat(lira_pkg::OP_FILL, 8'h5A, 18'h2AAAA, 1'b1);
    send_beat(lira_pkg::OP_SAMPLE, 8'h00, 18'd2, 1'b0);
  endtask

  // Width zero, oversized and small; position past the new width restarts
  task automatic test_width_extremes();
    apply_setting(16'd0, 16'hFFFF);
    send_beat(lira_pkg::OP_SAMPLE, 8'h55, 18'd5, 1'b1);
    send_beat(lira_pkg::OP_FILL, 8'hFF, 18'h3FFFF, 1'b0);
    apply_setting(16'hFFFF, 16'hFFFF);
    send_beat(lira_pkg::OP_SAMPLE, 8'h81, 18'd8, 1'b1);       // column 8191
    apply_setting(16'd2, 16'hFFFF);
    send_beat(lira_pkg::OP_SAMPLE, 8'h12, 18'd3, 1'b0);
    send_beat(lira_pkg::OP_SAMPLE, 8'h34, 18'd4, 1'b1);
    send_beat(lira_pkg::OP_SAMPLE, 8'h56, 18'd5, 1'b0);
    apply_setting(16'd1, 16'hFFFF);
    send_beat(lira_pkg::OP_SAMPLE, 8'h7E, 18'd11, 1'b1);
  endtask

  // Finished image: blue and fill give nothing, red still lands in the store
  task automatic test_image_complete();
    apply_setting(16'd3, 16'd0);
    send_beat(lira_pkg::OP_SAMPLE, 8'h12, 18'd3, 1'b0);
    send_beat(lira_pkg::OP_SAMPLE, 8'h34, 18'd5, 1'b0);
    send_beat(lira_pkg::OP_FILL, 8'h00, 18'd0, 1'b0);
    apply_setting(16'd3, lira_pkg::CFG_DATA_W'(lines_m + 1));
    repeat (4) send_beat(lira_pkg::OP_FILL, 8'h00, 18'd0, 1'b1);
    send_beat(lira_pkg::OP_SAMPLE, 8'hC3, 18'd2, 1'b1);
    apply_setting(16'd8192, 16'hFFFF);
  endtask

  // One scan line as three rows, optionally cut short
  task automatic send_scan_line(input int w, input bit broken);
    int   base;
    int   len;
    int   cut_ch;
    logic m_line;
    logic m;
    base   = 3 * $urandom_range(0, 87381);
    m_line = $urandom_range(0, 1);
    cut_ch = $urandom_range(0, 2);
    for (int ch = 0; ch < 3; ch++) begin
      m   = ($urandom_range(0, 3) == 0) ? logic'($urandom_range(0, 1)) : m_line;
      len = w;
      if (w > 64) len = $urandom_range(1, 20);
      else if (broken && ch == cut_ch) len = $urandom_range(0, w - 1);
      for (int i = 0; i < len; i++)
        send_beat(lira_pkg::OP_SAMPLE, lira_pkg::SAMPLE_W'($urandom),
                  lira_pkg::ROW_NUM_W'(base + ch), m);
    end
  endtask

  // Random settings, scan lines, fill runs and noise
  task automatic test_random_lines();
    logic [lira_pkg::CFG_DATA_W-1:0] w_cfg;
    int                              h_cfg;
    int                              w;
    int                              pick;
    int                              n;
    while (beats_sent < TOTAL_BEATS) begin
      case ($urandom_range(0, 15))
        0:       w_cfg = 16'd0;
        1:       w_cfg = 16'hFFFF;
        2:       w_cfg = 16'd8192;
        3, 4:    w_cfg = lira_pkg::CFG_DATA_W'($urandom_range(13, 64));
        default: w_cfg = lira_pkg::CFG_DATA_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       h_cfg = 0;
        1, 2:    h_cfg = 65535;
        3, 4:    h_cfg = int'(lines_m) + $urandom_range(0, 2);
        default: h_cfg = int'(lines_m) + $urandom_range(1, 40);
      endcase
      if (h_cfg > 65535) h_cfg = 65535;
      apply_setting(w_cfg, lira_pkg::CFG_DATA_W'(h_cfg));
      w = active_width();
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          send_scan_line(w, pick >= 11);
        end else if (pick < 16) begin
          n = $urandom_range(1, (2 * w < 24) ? 2 * w : 24);
          repeat (n) send_beat(lira_pkg::OP_FILL, lira_pkg::SAMPLE_W'($urandom),
                               lira_pkg::ROW_NUM_W'($urandom),
                               logic'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 8))
            send_beat(logic'($urandom_range(0, 1)), lira_pkg::SAMPLE_W'($urandom),
                      lira_pkg::ROW_NUM_W'($urandom), logic'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_prediction();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_width_extremes();
    test_image_complete();
    test_random_lines();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
